@@ hdl/ksd_pkg.sv @@
// Package for the key scan debounce block.
// Holds the shared types, register indexes, reset values and helper functions.
// Depends on nothing.
`default_nettype none

package ksd_pkg;

    localparam int NUM_KEYS_DEF = 39;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_MAP_WRITE = 1'b1;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_SAMPLES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_SAMPLES = 2'd2;

    localparam logic [7:0] LEVEL_THRESHOLD_RST = 8'h0A;
    localparam logic [7:0] ON_SAMPLES_RST = 8'd7;
    localparam logic [7:0] OFF_SAMPLES_RST = 8'd5;

    localparam logic [9:0] VEL_OFFSET = 10'd5;
    localparam logic [6:0] VEL_MAX = 7'd127;
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic       pressed;
        logic [7:0] on_cnt;
        logic [7:0] off_cnt;
    } key_state_t;

    typedef struct packed {
        logic [7:0] threshold;
        logic [7:0] on_needed;
        logic [7:0] off_needed;
    } debounce_cfg_t;

    typedef struct packed {
        logic       event_valid;
        logic [6:0] pitch;
        logic [6:0] velocity;
        logic [5:0] key_number;
        logic       scan_done;
    } note_result_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + 8'd1;
    endfunction

    function automatic logic [6:0] press_velocity(input logic [7:0] level);
        logic [9:0] sum;
        sum = {1'b0, level, 1'b0} + VEL_OFFSET;
        press_velocity = (sum > {3'b000, VEL_MAX}) ? VEL_MAX : sum[6:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/ksd_state_mem.sv @@
// Per-key debounce state memory with per-entry valid bits and write bypass.
// Uses key_state_t from ksd_pkg.
`default_nettype none

module ksd_state_mem import ksd_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF,
    parameter int KEY_W = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [KEY_W-1:0] rd_addr,
    output key_state_t            rd_data,
    input  wire logic             wr_en,
    input  wire logic [KEY_W-1:0] wr_addr,
    input  wire key_state_t       wr_data
);

    key_state_t mem_reg [NUM_KEYS];
    logic [NUM_KEYS-1:0] vld_reg;
    key_state_t rd_data_reg;
    logic rd_vld_reg;
    logic bypass;

    assign bypass = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= bypass ? wr_data : mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= bypass || vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

@@ hdl/ksd_pitch_mem.sv @@
// Pitch map memory, one note number per key, with write bypass on the read port.
// Uses constants from ksd_pkg.
`default_nettype none

module ksd_pitch_mem import ksd_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF,
    parameter int KEY_W = 1
) (
    input  wire logic             aclk,
    input  wire logic             rd_en,
    input  wire logic [KEY_W-1:0] rd_addr,
    output logic [6:0]            rd_data,
    input  wire logic             wr_en,
    input  wire logic [KEY_W-1:0] wr_addr,
    input  wire logic [6:0]       wr_data
);

    logic [6:0] mem_reg [NUM_KEYS];
    logic [6:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/ksd_update.sv @@
// Debounce update for one key sample: new run counts, pressed flag and note result.
// Uses the types and helper functions of ksd_pkg.
`default_nettype none

module ksd_update import ksd_pkg::*; (
    input  wire logic       mode,
    input  wire logic [7:0] level,
    input  wire logic [5:0] key_number,
    input  wire logic       scan_done,
    input  wire debounce_cfg_t cfg,
    input  wire key_state_t    cur_state,
    input  wire logic [6:0] pitch,
    output key_state_t      new_state,
    output note_result_t    result
);

    logic hit;
    logic on_flag;
    logic off_met;
    logic next_pressed;
    logic change;

    always_comb begin
        hit = level > cfg.threshold;
        new_state.on_cnt = hit ? sat_inc(cur_state.on_cnt) : 8'd0;
        new_state.off_cnt = hit ? 8'd0 : sat_inc(cur_state.off_cnt);
        on_flag = new_state.on_cnt >= cfg.on_needed;
        off_met = new_state.off_cnt >= cfg.off_needed;
        next_pressed = on_flag || (!off_met && cur_state.pressed);
        new_state.pressed = next_pressed;
        change = next_pressed != cur_state.pressed;

        result = '0;
        if (mode == MODE_SAMPLE) begin
            result.event_valid = change;
            result.pitch = change ? pitch : 7'd0;
            result.velocity = (change && next_pressed) ? press_velocity(level) : 7'd0;
            result.key_number = key_number;
            result.scan_done = scan_done;
        end
    end

endmodule

`default_nettype wire

@@ hdl/key_scan_debounce_note_events_unit.sv @@
// Key scan debouncer that turns per-key level samples into note on/off events.
// Sample requests enter on the s_ stream, one result per request leaves on the m_ stream.
// Configuration writes use the cfg_ channel, which is always ready.
// A sample request (tuser 0) carries the level of the current key; the internal key
// index advances after each sample and wraps at NUM_KEYS or when tlast is set.
// A map request (tuser 1) loads one pitch entry and returns an all-zero result.
// Each result carries tuser = event flag and tlast = scan wrapped.
// The accepting edge registers the request and reads the per-key state memory; once the output
// register is free, the state is updated and the result is loaded into the output register,
// which drives m_tvalid.
// Throughput is one request per cycle while the receiver takes results; a same-key write back
// is forwarded into the next read, so consecutive samples of one key also run back to back.
// When the receiver stalls, the output register and the input stage hold, and
// s_tready drops only once both are full.
// Reset returns the registers to their defaults, the key index to zero and all keys
// to released with cleared run counts; pitch entries stay undefined until loaded.
// Depends on ksd_pkg, ksd_state_mem, ksd_pitch_mem and ksd_update.
`default_nettype none

module key_scan_debounce_note_events_unit import ksd_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [23:0]            s_tdata,   // level[7:0], map_index[13:8], map_pitch[20:14]
    input  wire logic                   s_tuser,   // mode
    input  wire logic                   s_tlast,   // scan end flag
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [23:0]                 m_tdata,   // pitch[6:0], velocity[13:7], key_number[19:14]
    output logic                        m_tuser,   // event_valid
    output logic                        m_tlast,   // scan_done
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);
    localparam logic [6:0] NUM_KEYS_EXT = 7'(NUM_KEYS);

    debounce_cfg_t cfg_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic scan_wrap;

    logic s1_valid_reg;
    logic s1_mode_reg;
    logic [7:0] s1_level_reg;
    logic s1_done_reg;
    logic [KEY_W-1:0] s1_key_reg;
    logic [5:0] s1_map_index_reg;
    logic [6:0] s1_map_pitch_reg;

    logic m_tvalid_reg;
    note_result_t result_reg;

    logic out_free;
    logic s1_adv;
    logic accept;
    logic state_wr;
    logic pitch_wr;

    key_state_t cur_state;
    key_state_t new_state;
    logic [6:0] cur_pitch;
    note_result_t result;

    assign cfg_ready = 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_adv = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept = s_tvalid && s_tready;

    assign scan_wrap = (key_reg == LAST_KEY) || s_tlast;
    assign key_next = scan_wrap ? '0 : key_reg + KEY_W'(1);

    assign state_wr = s1_adv && (s1_mode_reg == MODE_SAMPLE);
    assign pitch_wr = s1_adv && (s1_mode_reg == MODE_MAP_WRITE)
                      && ({1'b0, s1_map_index_reg} < NUM_KEYS_EXT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= LEVEL_THRESHOLD_RST;
            cfg_reg.on_needed <= ON_SAMPLES_RST;
            cfg_reg.off_needed <= OFF_SAMPLES_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LEVEL_THRESHOLD: cfg_reg.threshold <= cfg_data;
                REG_ON_SAMPLES: cfg_reg.on_needed <= cfg_data;
                REG_OFF_SAMPLES: cfg_reg.off_needed <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept && (s_tuser == MODE_SAMPLE)) begin
                key_reg <= key_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mode_reg <= s_tuser;
            s1_level_reg <= s_tdata[7:0];
            s1_done_reg <= scan_wrap;
            s1_key_reg <= key_reg;
            s1_map_index_reg <= s_tdata[13:8];
            s1_map_pitch_reg <= s_tdata[20:14];
        end
        if (s1_adv) begin
            result_reg <= result;
        end
    end

    ksd_state_mem #(
        .NUM_KEYS(NUM_KEYS),
        .KEY_W(KEY_W)
    ) u_state_mem (
        .aclk(aclk),
        .aresetn(aresetn),
        .rd_en(accept),
        .rd_addr(key_reg),
        .rd_data(cur_state),
        .wr_en(state_wr),
        .wr_addr(s1_key_reg),
        .wr_data(new_state)
    );

    ksd_pitch_mem #(
        .NUM_KEYS(NUM_KEYS),
        .KEY_W(KEY_W)
    ) u_pitch_mem (
        .aclk(aclk),
        .rd_en(accept),
        .rd_addr(key_reg),
        .rd_data(cur_pitch),
        .wr_en(pitch_wr),
        .wr_addr(s1_map_index_reg[KEY_W-1:0]),
        .wr_data(s1_map_pitch_reg)
    );

    ksd_update u_update (
        .mode(s1_mode_reg),
        .level(s1_level_reg),
        .key_number(6'(s1_key_reg)),
        .scan_done(s1_done_reg),
        .cfg(cfg_reg),
        .cur_state(cur_state),
        .pitch(cur_pitch),
        .new_state(new_state),
        .result(result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {4'd0, result_reg.key_number, result_reg.velocity, result_reg.pitch};
    assign m_tuser = result_reg.event_valid;
    assign m_tlast = result_reg.scan_done;

endmodule

`default_nettype wire

@@ test/ksd_note_checker.sv @@
`timescale 1ns / 100ps
// Checker for the key scan debounce unit: watches the sample, result and register channels.
// Keeps its own debounce state and pitch table, predicts one note result per request and
// compares every result field by field. Depends on ksd_pkg.
module ksd_note_checker import ksd_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [23:0]            s_tdata,
    input  wire logic                   s_tuser,
    input  wire logic                   s_tlast,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [23:0]            m_tdata,
    input  wire logic                   m_tuser,
    input  wire logic                   m_tlast,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data,
    output int                          fail_count,
    output int                          pending
);

    debounce_cfg_t  db_cfg;
    logic [5:0]     scan_key;
    logic           key_down  [NUM_KEYS];
    logic [7:0]     hit_run   [NUM_KEYS];
    logic [7:0]     miss_run  [NUM_KEYS];
    logic [6:0]     pitch_tbl [NUM_KEYS];
    note_result_t   note_q[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic predict_note(input logic mode, input logic [7:0] level, input logic eos,
                                input logic [5:0] map_idx, input logic [6:0] map_pitch);
        note_result_t res;
        int           k;
        int           vel;
        logic         hit;
        logic         next_down;
        logic         wrapped;
        res = '0;
        if (mode == MODE_MAP_WRITE) begin
            if (map_idx < NUM_KEYS) begin
                pitch_tbl[map_idx] = map_pitch;
            end
        end else begin
            k = (scan_key >= NUM_KEYS) ? 0 : int'(scan_key);
            hit = level > db_cfg.threshold;
            if (hit) begin
                miss_run[k] = 8'd0;
                hit_run[k] = (hit_run[k] == 8'hFF) ? 8'hFF : hit_run[k] + 8'd1;
            end else begin
                hit_run[k] = 8'd0;
                miss_run[k] = (miss_run[k] == 8'hFF) ? 8'hFF : miss_run[k] + 8'd1;
            end
            next_down = (hit_run[k] >= db_cfg.on_needed) ||
                        (!(miss_run[k] >= db_cfg.off_needed) && key_down[k]);
            if (next_down != key_down[k]) begin
                res.event_valid = 1'b1;
                res.pitch = pitch_tbl[k];
                if (next_down) begin
                    vel = int'(level) * 2 + 5;
                    res.velocity = (vel > 127) ? 7'd127 : vel[6:0];
                end
            end
            key_down[k] = next_down;
            res.key_number = k[5:0];
            wrapped = (k + 1 >= NUM_KEYS) || eos;
            scan_key = wrapped ? 6'd0 : k[5:0] + 6'd1;
            res.scan_done = wrapped;
        end
        note_q.push_back(res);
    endtask

    always @(posedge aclk) begin
        note_result_t want_note;
        if (!aresetn) begin
            db_cfg.threshold = LEVEL_THRESHOLD_RST;
            db_cfg.on_needed = ON_SAMPLES_RST;
            db_cfg.off_needed = OFF_SAMPLES_RST;
            scan_key = 6'd0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                key_down[i] = 1'b0;
                hit_run[i] = 8'd0;
                miss_run[i] = 8'd0;
                pitch_tbl[i] = 7'd0;
            end
            note_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LEVEL_THRESHOLD: db_cfg.threshold = cfg_data;
                    REG_ON_SAMPLES:      db_cfg.on_needed = cfg_data;
                    REG_OFF_SAMPLES:     db_cfg.off_needed = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (note_q.size() == 0) begin
                    report_mismatch("result count, a result came with no request waiting", 1, 0);
                end else begin
                    want_note = note_q.pop_front();
                    if (m_tuser !== want_note.event_valid)
                        report_mismatch("event_valid", m_tuser, want_note.event_valid);
                    if (m_tdata[6:0] !== want_note.pitch)
                        report_mismatch("pitch", m_tdata[6:0], want_note.pitch);
                    if (m_tdata[13:7] !== want_note.velocity)
                        report_mismatch("velocity", m_tdata[13:7], want_note.velocity);
                    if (m_tdata[19:14] !== want_note.key_number)
                        report_mismatch("key_number", m_tdata[19:14], want_note.key_number);
                    if (m_tlast !== want_note.scan_done)
                        report_mismatch("scan_done", m_tlast, want_note.scan_done);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_note(s_tuser, s_tdata[7:0], s_tlast, s_tdata[13:8], s_tdata[20:14]);
            end
        end
        pending = note_q.size();
    end

endmodule

@@ test/tb_key_scan_debounce_note_events_unit.sv @@
`timescale 1ns / 100ps
// Top of the key scan debounce testbench: clock, reset, sample and register stimulus.
// Results are predicted and checked by ksd_note_checker; this module gives the verdict.
// Depends on ksd_pkg, ksd_note_checker and key_scan_debounce_note_events_unit.
module tb_key_scan_debounce_note_events_unit;
    import ksd_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [23:0]            s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [23:0]            m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;
    int                     fail_count;
    int                     pending;

    int         send_idle = 22;
    int         recv_idle = 81;
    logic [7:0] thr_now = LEVEL_THRESHOLD_RST;
    logic [5:0] stim_key = 6'd0;
    logic       want_down [64];

    always #6 aclk = ~aclk;

    key_scan_debounce_note_events_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ksd_note_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_item(input logic mode, input logic [7:0] level, input logic eos,
                             input logic [5:0] map_idx, input logic [6:0] map_pitch);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, map_pitch, map_idx, level};
        s_tuser <= mode;
        s_tlast <= eos;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (mode == MODE_SAMPLE) begin
            stim_key = (eos || stim_key == NUM_KEYS_DEF - 1) ? 6'd0 : stim_key + 6'd1;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_debounce(input logic [7:0] thr, input logic [7:0] on_n,
                                input logic [7:0] off_n);
        write_reg(REG_LEVEL_THRESHOLD, thr);
        write_reg(REG_ON_SAMPLES, on_n);
        write_reg(REG_OFF_SAMPLES, off_n);
        thr_now = thr;
    endtask

    function automatic logic [7:0] pick_level(input logic hit);
        if (hit && thr_now != 8'hFF) return 8'($urandom_range(255, 32'(thr_now) + 1));
        if (hit) return 8'($urandom);
        return 8'($urandom_range(32'(thr_now), 0));
    endfunction

    // Each key follows a slowly changing pressed or released intent, with some noisy
    // samples that break runs, a scan of scan_len keys and now and then a map write.
    task automatic run_scan_phase(input int count, input int scan_len, input int pause_at);
        logic hit;
        logic eos;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
                drain_results();
            end
            if ($urandom_range(99) < 4) begin
                send_item(MODE_MAP_WRITE, 8'($urandom), 1'($urandom), 6'($urandom),
                          7'($urandom));
            end else begin
                if ($urandom_range(19) == 0) want_down[stim_key] = ~want_down[stim_key];
                hit = want_down[stim_key];
                if ($urandom_range(9) == 0) hit = ~hit;
                eos = (scan_len < NUM_KEYS_DEF && stim_key == scan_len - 1) ||
                      ($urandom_range(49) == 0);
                send_item(MODE_SAMPLE, pick_level(hit), eos, 6'($urandom), 7'($urandom));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 64; i++) want_down[i] = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Every pitch entry is loaded before any sample, so no event reads an empty entry.
        for (int k = 0; k < NUM_KEYS_DEF; k++) begin
            send_item(MODE_MAP_WRITE, 8'h00, 1'b0, k[5:0],
                      (k == 0) ? 7'd0 : (k == 1) ? 7'd127 : 7'((k * 29 + 3) % 128));
        end
        send_item(MODE_MAP_WRITE, 8'hFF, 1'b1, 6'd39, 7'h55);
        send_item(MODE_MAP_WRITE, 8'hAA, 1'b1, 6'd63, 7'h7F);
        drain_results();
        write_reg(REG_ON_SAMPLES, 8'd1);
        write_reg(REG_OFF_SAMPLES, 8'd1);

        // Key zero alone: threshold boundary, pitch zero events and velocity saturation.
        send_item(MODE_SAMPLE, 8'd10, 1'b1, 6'h3F, 7'h7F);
        send_item(MODE_SAMPLE, 8'd11, 1'b1, 6'h00, 7'h00);
        send_item(MODE_SAMPLE, 8'd255, 1'b1, 6'h3F, 7'h7F);
        send_item(MODE_SAMPLE, 8'd0, 1'b1, 6'h00, 7'h00);
        send_item(MODE_SAMPLE, 8'd61, 1'b1, 6'h00, 7'h00);
        send_item(MODE_SAMPLE, 8'd0, 1'b1, 6'h00, 7'h00);
        send_item(MODE_SAMPLE, 8'd62, 1'b1, 6'h00, 7'h00);
        send_item(MODE_SAMPLE, 8'd0, 1'b1, 6'h00, 7'h00);
        // A short scan with a map write in the middle that must not move the key index.
        send_item(MODE_SAMPLE, 8'd255, 1'b0, 6'h00, 7'h00);
        send_item(MODE_SAMPLE, 8'd200, 1'b0, 6'h00, 7'h00);
        send_item(MODE_MAP_WRITE, 8'hFF, 1'b1, 6'd2, 7'd127);
        send_item(MODE_SAMPLE, 8'd128, 1'b0, 6'h00, 7'h00);
        send_item(MODE_SAMPLE, 8'd0, 1'b0, 6'h00, 7'h00);
        send_item(MODE_SAMPLE, 8'd1, 1'b0, 6'h00, 7'h00);
        send_item(MODE_SAMPLE, 8'd0, 1'b1, 6'h00, 7'h00);
        drain_results();

        set_debounce(8'd10, 8'd7, 8'd5);
        run_scan_phase(150, 4, 75);
        drain_results();

        set_debounce(8'd0, 8'd1, 8'd1);
        run_scan_phase(150, NUM_KEYS_DEF, -1);
        drain_results();

        send_idle = 81;
        recv_idle = 22;
        set_debounce(8'd255, 8'd255, 8'd255);
        run_scan_phase(100, 8, -1);
        drain_results();

        // Long pressed run on key zero: the key turns on exactly at a count of 255.
        set_debounce(8'd128, 8'd255, 8'd255);
        send_item(MODE_SAMPLE, 8'd0, 1'b1, 6'($urandom), 7'($urandom));
        repeat (265) send_item(MODE_SAMPLE, 8'($urandom_range(255, 129)), 1'b1,
                               6'($urandom), 7'($urandom));
        repeat (10) send_item(MODE_SAMPLE, 8'($urandom_range(128, 0)), 1'b1,
                              6'($urandom), 7'($urandom));
        drain_results();

        send_idle = 0;
        recv_idle = 0;
        set_debounce(8'($urandom_range(200, 20)), 8'd0, 8'($urandom_range(10, 1)));
        run_scan_phase(70, 3, -1);
        drain_results();

        set_debounce(8'($urandom), 8'($urandom_range(12, 1)), 8'($urandom_range(12, 1)));
        run_scan_phase(60, $urandom_range(NUM_KEYS_DEF, 1), -1);
        drain_results();

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ key_scan_debounce_note_events_unit.f @@
hdl/ksd_pkg.sv
hdl/ksd_state_mem.sv
hdl/ksd_pitch_mem.sv
hdl/ksd_update.sv
hdl/key_scan_debounce_note_events_unit.sv
test/ksd_note_checker.sv
test/tb_key_scan_debounce_note_events_unit.sv
